// ===== rtl/cbfs_pkg.sv =====
// cbfs_pkg: shared constants, types and threshold function for the flood suppressor
// used by cbfs_pend, cbfs_seen and counter_based_flood_suppressor_unit
package cbfs_pkg;

	localparam int SEEN_DEPTH_DEF = 64;
	localparam int PEND_DEPTH_DEF = 16;
	localparam int ID_W           = 32;
	localparam int CNT_W          = 4;
	localparam int NC_W           = 8;

	localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;
	localparam logic [CNT_W-1:0] COUNT_ONE = 4'd1;

	localparam logic OP_RX     = 1'b0;
	localparam logic OP_EXPIRE = 1'b1;

	// write command flags for the pending table
	typedef struct packed {
		logic wr;
		logic set_v;
		logic clr_v;
	} pend_cmd_t;

	// allowed receptions from the neighbor count
	function automatic logic [CNT_W-1:0] threshold_for(input logic [NC_W-1:0] n);
		logic [CNT_W-1:0] t;
		if (n <= 8'd5) begin
			if (n == 8'd1)
				t = 4'd2;
			else if (n == 8'd2 || n == 8'd3)
				t = n[CNT_W-1:0] + 4'd1;
			else
				t = 4'd5;
		end else if (n <= 8'd8) begin
			t = 4'd4;
		end else if (n <= 8'd11) begin
			t = 4'd3;
		end else begin
			t = 4'd2;
		end
		return t;
	endfunction

endpackage

// ===== rtl/cbfs_pend.sv =====
// cbfs_pend: pending table, id and copy count per entry with valid flags
// depends on cbfs_pkg
module cbfs_pend #(
	parameter int PEND_DEPTH = cbfs_pkg::PEND_DEPTH_DEF,
	parameter int PI = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [PI-1:0]               rd_addr,
	output logic [cbfs_pkg::ID_W-1:0]   rd_id,
	output logic [cbfs_pkg::CNT_W-1:0]  rd_count,
	output logic                        rd_valid,
	input  cbfs_pkg::pend_cmd_t         cmd,
	input  logic [PI-1:0]               wr_addr,
	input  logic [cbfs_pkg::ID_W-1:0]   wr_id,
	input  logic [cbfs_pkg::CNT_W-1:0]  wr_count
);

	logic [cbfs_pkg::ID_W+cbfs_pkg::CNT_W-1:0] mem [PEND_DEPTH];
	logic [PEND_DEPTH-1:0]                     valid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem[wr_addr] <= {wr_id, wr_count};
		{rd_id, rd_count} <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (cmd.set_v)
				valid_q[wr_addr] <= 1'b1;
			else if (cmd.clr_v)
				valid_q[wr_addr] <= 1'b0;
			rd_valid <= valid_q[rd_addr];
		end
	end

endmodule

// ===== rtl/cbfs_seen.sv =====
// cbfs_seen: ring of recently seen ids, oldest overwritten, with valid flags
// depends on cbfs_pkg
module cbfs_seen #(
	parameter int SEEN_DEPTH = cbfs_pkg::SEEN_DEPTH_DEF,
	parameter int SI = $clog2(SEEN_DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [SI-1:0]             rd_addr,
	output logic [cbfs_pkg::ID_W-1:0] rd_id,
	output logic                      rd_valid,
	input  logic                      push,
	input  logic [cbfs_pkg::ID_W-1:0] push_id
);

	logic [cbfs_pkg::ID_W-1:0] mem [SEEN_DEPTH];
	logic [SEEN_DEPTH-1:0]     valid_q;
	logic [SI-1:0]             next_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[next_q] <= push_id;
		rd_id <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			next_q   <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (push) begin
				valid_q[next_q] <= 1'b1;
				if (next_q == SI'(SEEN_DEPTH - 1))
					next_q <= '0;
				else
					next_q <= next_q + 1'b1;
			end
			rd_valid <= valid_q[rd_addr];
		end
	end

endmodule

// ===== rtl/counter_based_flood_suppressor_unit.sv =====
// counter_based_flood_suppressor_unit: sequencer with one shared id comparator
// depends on cbfs_pkg, cbfs_pend, cbfs_seen
// steps: pending-table scan, seen-ring scan for a reception missing the pending table,
// then the finish state and the done strobe; the scans read one entry per cycle
// one word at a time, busy from accept until the strobe; next start taken with the strobe
// reset clears all valid flags, the ring pointer and the sequencer; results cannot stall
module counter_based_flood_suppressor_unit #(
	parameter int SEEN_DEPTH = cbfs_pkg::SEEN_DEPTH_DEF,
	parameter int PEND_DEPTH = cbfs_pkg::PEND_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [cbfs_pkg::ID_W-1:0]  msg_id,
	input  logic [cbfs_pkg::NC_W-1:0]  neighbor_count,
	output logic                       done,
	output logic                       first_reception,
	output logic                       start_timer,
	output logic                       cancel_timer,
	output logic                       forward,
	output logic [cbfs_pkg::CNT_W-1:0] copies,
	output logic                       table_full
);

	localparam int PI = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
	localparam int SI = $clog2(SEEN_DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_PSCAN  = 2'd1;
	localparam logic [1:0] ST_SSCAN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]                 state_q;
	logic                       op_q;
	logic [cbfs_pkg::ID_W-1:0]  id_q;
	logic [cbfs_pkg::CNT_W-1:0] thr_q;
	logic [PI-1:0]              pidx_q;
	logic [SI-1:0]              sidx_q;
	logic                       issue_q;
	logic                       vld_s1;
	logic                       last_s1;
	logic [PI-1:0]              pidx_s1;
	logic                       pmatch_q;
	logic [PI-1:0]              pmatch_idx_q;
	logic [cbfs_pkg::CNT_W-1:0] pcnt_q;
	logic                       free_q;
	logic [PI-1:0]              free_idx_q;
	logic                       seen_hit_q;

	logic                       done_q;
	logic                       first_q;
	logic                       start_q;
	logic                       cancel_q;
	logic                       fwd_q;
	logic [cbfs_pkg::CNT_W-1:0] copies_q;
	logic                       full_q;

	logic [cbfs_pkg::ID_W-1:0]  prd_id;
	logic [cbfs_pkg::CNT_W-1:0] prd_count;
	logic                       prd_valid;
	logic [cbfs_pkg::ID_W-1:0]  srd_id;
	logic                       srd_valid;

	logic [cbfs_pkg::ID_W-1:0]  cmp_id;
	logic                       cmp_valid;
	logic                       id_eq;
	logic                       cur_last;
	logic                       hit;

	cbfs_pkg::pend_cmd_t        pcmd;
	logic [PI-1:0]              pwr_addr;
	logic [cbfs_pkg::CNT_W-1:0] pwr_count;
	logic                       spush;
	logic [cbfs_pkg::CNT_W-1:0] inc_cnt;
	logic                       is_new;

	cbfs_pend #(
		.PEND_DEPTH(PEND_DEPTH),
		.PI(PI)
	) u_pend (
		.clk(clk),
		.arst_n(arst_n),
		.rd_addr(pidx_q),
		.rd_id(prd_id),
		.rd_count(prd_count),
		.rd_valid(prd_valid),
		.cmd(pcmd),
		.wr_addr(pwr_addr),
		.wr_id(id_q),
		.wr_count(pwr_count)
	);

	cbfs_seen #(
		.SEEN_DEPTH(SEEN_DEPTH),
		.SI(SI)
	) u_seen (
		.clk(clk),
		.arst_n(arst_n),
		.rd_addr(sidx_q),
		.rd_id(srd_id),
		.rd_valid(srd_valid),
		.push(spush),
		.push_id(id_q)
	);

	// shared id comparator
	assign cmp_id    = (state_q == ST_SSCAN) ? srd_id : prd_id;
	assign cmp_valid = (state_q == ST_SSCAN) ? srd_valid : prd_valid;
	assign id_eq     = (cmp_id == id_q);
	assign hit       = vld_s1 && cmp_valid && id_eq;
	assign cur_last  = (state_q == ST_SSCAN) ? (sidx_q == SI'(SEEN_DEPTH - 1))
	                                         : (pidx_q == PI'(PEND_DEPTH - 1));

	assign inc_cnt = (pcnt_q == cbfs_pkg::COUNT_MAX) ? pcnt_q : pcnt_q + 1'b1;
	assign is_new  = (op_q == cbfs_pkg::OP_RX) && !pmatch_q && !seen_hit_q;

	always_comb begin
		pcmd      = '0;
		pwr_addr  = pmatch_idx_q;
		pwr_count = inc_cnt;
		spush     = 1'b0;
		if (state_q == ST_FINISH) begin
			if (is_new) begin
				spush = 1'b1;
				if (free_q) begin
					pcmd.wr    = 1'b1;
					pcmd.set_v = 1'b1;
					pwr_addr   = free_idx_q;
					pwr_count  = cbfs_pkg::COUNT_ONE;
				end
			end else if (pmatch_q) begin
				if (op_q == cbfs_pkg::OP_RX) begin
					pcmd.wr    = 1'b1;
					pcmd.clr_v = (inc_cnt >= thr_q);
				end else begin
					pcmd.clr_v = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q  <= op;
			id_q  <= msg_id;
			thr_q <= cbfs_pkg::threshold_for(neighbor_count);
		end
		if (issue_q)
			pidx_s1 <= pidx_q;
		if (state_q == ST_FINISH) begin
			first_q <= is_new;
			start_q <= is_new && free_q;
			full_q  <= is_new && !free_q;
			if (is_new) begin
				copies_q <= cbfs_pkg::COUNT_ONE;
				cancel_q <= 1'b0;
				fwd_q    <= 1'b0;
			end else if (pmatch_q && op_q == cbfs_pkg::OP_RX) begin
				copies_q <= inc_cnt;
				cancel_q <= (inc_cnt >= thr_q);
				fwd_q    <= 1'b0;
			end else if (pmatch_q) begin
				copies_q <= pcnt_q;
				cancel_q <= 1'b0;
				fwd_q    <= (pcnt_q < thr_q);
			end else begin
				copies_q <= '0;
				cancel_q <= 1'b0;
				fwd_q    <= 1'b0;
			end
		end
		if (state_q == ST_PSCAN && hit && !pmatch_q) begin
			pmatch_idx_q <= pidx_s1;
			pcnt_q       <= prd_count;
		end
		if (state_q == ST_PSCAN && vld_s1 && !prd_valid && !free_q)
			free_idx_q <= pidx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pidx_q     <= '0;
			sidx_q     <= '0;
			issue_q    <= 1'b0;
			vld_s1     <= 1'b0;
			last_s1    <= 1'b0;
			pmatch_q   <= 1'b0;
			free_q     <= 1'b0;
			seen_hit_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q  <= (state_q == ST_FINISH);
			vld_s1  <= issue_q;
			last_s1 <= issue_q && cur_last;
			if (issue_q) begin
				if (cur_last)
					issue_q <= 1'b0;
				else if (state_q == ST_SSCAN)
					sidx_q <= sidx_q + 1'b1;
				else
					pidx_q <= pidx_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q    <= ST_PSCAN;
						pidx_q     <= '0;
						sidx_q     <= '0;
						issue_q    <= 1'b1;
						pmatch_q   <= 1'b0;
						free_q     <= 1'b0;
						seen_hit_q <= 1'b0;
					end
				end
				ST_PSCAN: begin
					if (hit)
						pmatch_q <= 1'b1;
					if (vld_s1 && !prd_valid)
						free_q <= 1'b1;
					if (vld_s1 && last_s1) begin
						if (op_q == cbfs_pkg::OP_RX && !hit && !pmatch_q) begin
							state_q <= ST_SSCAN;
							issue_q <= 1'b1;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SSCAN: begin
					if (hit)
						seen_hit_q <= 1'b1;
					if (vld_s1 && last_s1)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign first_reception = first_q;
	assign start_timer     = start_q;
	assign cancel_timer    = cancel_q;
	assign forward         = fwd_q;
	assign copies          = copies_q;
	assign table_full      = full_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// testbench for counter_based_flood_suppressor_unit: directed and random receptions and expiries,
// checked word by word against a built-in predictor of the seen ring and pending table
// depends on cbfs_pkg and counter_based_flood_suppressor_unit
module testbench;

	localparam int SEEN_N  = cbfs_pkg::SEEN_DEPTH_DEF;
	localparam int PEND_N  = cbfs_pkg::PEND_DEPTH_DEF;
	localparam int POOL_N  = 20;
	localparam int PHASE_N = 310;

	typedef logic [cbfs_pkg::ID_W-1:0]  id_t;
	typedef logic [cbfs_pkg::NC_W-1:0]  nc_t;
	typedef logic [cbfs_pkg::CNT_W-1:0] cnt_t;

	typedef struct {
		logic        ev_op;
		id_t         id;
		nc_t         nc;
		int unsigned idle_pct;
		bit          drain;
	} flood_event_t;

	typedef struct packed {
		logic first;
		logic timer_start;
		logic timer_cancel;
		logic fwd;
		cnt_t cnt;
		logic full;
	} flood_action_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic op = 1'b0;
	id_t  msg_id = '0;
	nc_t  neighbor_count = '0;
	logic busy;
	logic done;
	logic first_reception;
	logic start_timer;
	logic cancel_timer;
	logic forward;
	cnt_t copies;
	logic table_full;

	flood_event_t  event_q[$];
	flood_action_t expected_actions[$];
	int unsigned   n_issued = 0;
	int unsigned   n_accepted = 0;
	int unsigned   fail_cnt = 0;
	int unsigned   n_first = 0;
	int unsigned   n_cancel = 0;
	int unsigned   n_fwd = 0;
	int unsigned   n_full = 0;

	// predictor state
	id_t  ring_id [SEEN_N];
	bit   ring_v [SEEN_N];
	int   ring_ptr = 0;
	id_t  pend_id [PEND_N];
	cnt_t pend_cnt [PEND_N];
	bit   pend_v [PEND_N];

	counter_based_flood_suppressor_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.msg_id(msg_id),
		.neighbor_count(neighbor_count),
		.done(done),
		.first_reception(first_reception),
		.start_timer(start_timer),
		.cancel_timer(cancel_timer),
		.forward(forward),
		.copies(copies),
		.table_full(table_full)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic cnt_t rx_limit(input nc_t n);
		if (n == 8'd1)
			return 4'd2;
		else if (n == 8'd2 || n == 8'd3)
			return n[cbfs_pkg::CNT_W-1:0] + 4'd1;
		else if (n <= 8'd5)
			return 4'd5;
		else if (n <= 8'd8)
			return 4'd4;
		else if (n <= 8'd11)
			return 4'd3;
		return 4'd2;
	endfunction

	function automatic flood_action_t decide_flood_action(input logic ev_op,
			input id_t id, input nc_t nc);
		flood_action_t a;
		int            p;
		int            f;
		bit            known;
		cnt_t          limit;
		cnt_t          c;
		a = '0;
		p = -1;
		f = -1;
		known = 1'b0;
		limit = rx_limit(nc);
		for (int i = 0; i < PEND_N; i++) begin
			if (pend_v[i] && pend_id[i] == id && p < 0)
				p = i;
			if (!pend_v[i] && f < 0)
				f = i;
		end
		for (int i = 0; i < SEEN_N; i++)
			if (ring_v[i] && ring_id[i] == id)
				known = 1'b1;
		if (ev_op == cbfs_pkg::OP_RX) begin
			if (p < 0 && !known) begin
				a.first = 1'b1;
				a.cnt = cbfs_pkg::COUNT_ONE;
				ring_id[ring_ptr] = id;
				ring_v[ring_ptr] = 1'b1;
				ring_ptr = (ring_ptr + 1) % SEEN_N;
				if (f >= 0) begin
					pend_id[f] = id;
					pend_cnt[f] = cbfs_pkg::COUNT_ONE;
					pend_v[f] = 1'b1;
					a.timer_start = 1'b1;
				end else begin
					a.full = 1'b1;
				end
			end else if (p >= 0) begin
				c = pend_cnt[p];
				if (c != cbfs_pkg::COUNT_MAX)
					c = c + 4'd1;
				pend_cnt[p] = c;
				a.cnt = c;
				if (c >= limit) begin
					a.timer_cancel = 1'b1;
					pend_v[p] = 1'b0;
				end
			end
		end else if (p >= 0) begin
			a.cnt = pend_cnt[p];
			a.fwd = (pend_cnt[p] < limit);
			pend_v[p] = 1'b0;
		end
		return a;
	endfunction

	task automatic check_field(input string fname, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			fail_cnt++;
		end
	endtask

	task automatic add_event(input logic ev_op, input id_t id,
			input nc_t nc, input int unsigned idle_pct, input bit drain);
		flood_event_t e;
		e.ev_op = ev_op;
		e.id = id;
		e.nc = nc;
		e.idle_pct = idle_pct;
		e.drain = drain;
		event_q.push_back(e);
	endtask

	// driver
	always @(negedge clk) begin
		flood_event_t e;
		if (arst_n && n_issued == n_accepted) begin
			if (event_q.size() != 0 && !(event_q[0].drain && expected_actions.size() != 0)
					&& $urandom_range(99) >= event_q[0].idle_pct) begin
				e = event_q.pop_front();
				start <= 1'b1;
				op <= e.ev_op;
				msg_id <= e.id;
				neighbor_count <= e.nc;
				n_issued++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		flood_action_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_actions.size() == 0) begin
					$display("%0t ns: result word with nothing expected", $time);
					fail_cnt++;
				end else begin
					want = expected_actions.pop_front();
					check_field("first_reception", int'(want.first), int'(first_reception));
					check_field("start_timer", int'(want.timer_start), int'(start_timer));
					check_field("cancel_timer", int'(want.timer_cancel), int'(cancel_timer));
					check_field("forward", int'(want.fwd), int'(forward));
					check_field("copies", int'(want.cnt), int'(copies));
					check_field("table_full", int'(want.full), int'(table_full));
				end
				n_first += int'(first_reception);
				n_cancel += int'(cancel_timer);
				n_fwd += int'(forward);
				n_full += int'(table_full);
			end
			if (start && !busy) begin
				expected_actions.push_back(decide_flood_action(op, msg_id, neighbor_count));
				n_accepted++;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("Mismatches found");
		$finish;
	end

	initial begin
		id_t         id_pool [POOL_N];
		id_t         fill_ids [PEND_N];
		id_t         id_a;
		id_t         id_b;
		id_t         id_c;
		id_t         id_x;
		id_t         id_n;
		id_t         id_full;
		nc_t         nc;
		int unsigned phase_idle [4];
		int unsigned r;
		int unsigned total;

		for (int i = 0; i < SEEN_N; i++)
			ring_v[i] = 1'b0;
		for (int i = 0; i < PEND_N; i++)
			pend_v[i] = 1'b0;

		// directed part
		id_a = 32'h0000_0000;
		id_b = 32'hFFFF_FFFF;
		id_c = 32'hA5A5_5A5A;
		add_event(cbfs_pkg::OP_RX, id_a, 8'd1, 0, 1'b0);
		add_event(cbfs_pkg::OP_RX, id_a, 8'd1, 0, 1'b0);
		add_event(cbfs_pkg::OP_RX, id_a, 8'd7, 0, 1'b0);      // known, no pending entry
		add_event(cbfs_pkg::OP_EXPIRE, id_a, 8'd0, 0, 1'b0);  // expiry without entry
		add_event(cbfs_pkg::OP_RX, id_b, 8'd0, 0, 1'b0);
		add_event(cbfs_pkg::OP_RX, id_b, 8'd2, 0, 1'b0);
		add_event(cbfs_pkg::OP_EXPIRE, id_b, 8'd3, 0, 1'b0);
		add_event(cbfs_pkg::OP_RX, id_c, 8'd255, 0, 1'b0);
		add_event(cbfs_pkg::OP_RX, id_c, 8'd12, 0, 1'b0);
		// fill the pending table, then one more new id
		for (int i = 0; i < PEND_N; i++) begin
			fill_ids[i] = $urandom;
			add_event(cbfs_pkg::OP_RX, fill_ids[i], (i == 0) ? 8'hFF : 8'd6, 0, 1'b0);
		end
		id_full = $urandom;
		add_event(cbfs_pkg::OP_RX, id_full, 8'd8, 0, 1'b0);

		// free the table
		for (int i = 0; i < PEND_N; i++)
			add_event(cbfs_pkg::OP_EXPIRE, fill_ids[i], nc_t'($urandom_range(15)), 0, i == 0);

		// push a pending id out of the seen ring
		id_x = $urandom;
		add_event(cbfs_pkg::OP_RX, id_x, 8'd0, 0, 1'b1);
		for (int i = 0; i < SEEN_N; i++) begin
			id_n = $urandom;
			add_event(cbfs_pkg::OP_RX, id_n, 8'd0, 0, 1'b0);
			add_event(cbfs_pkg::OP_EXPIRE, id_n, nc_t'($urandom_range(255)), 0, 1'b0);
		end
		add_event(cbfs_pkg::OP_RX, id_x, 8'd0, 0, 1'b0);
		add_event(cbfs_pkg::OP_EXPIRE, id_x, 8'd0, 0, 1'b0);

		// random part
		for (int i = 0; i < POOL_N; i++)
			id_pool[i] = (i < PEND_N) ? fill_ids[i] : $urandom;
		id_pool[POOL_N-1] = id_full;
		phase_idle[0] = 0;
		phase_idle[1] = 56;
		phase_idle[2] = 0;
		phase_idle[3] = 25;
		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < PHASE_N; k++) begin
				nc = ($urandom_range(3) != 0) ? nc_t'($urandom_range(15))
				                              : nc_t'($urandom_range(255));
				r = $urandom_range(99);
				if (r < 22) begin
					id_n = $urandom;
					id_pool[$urandom_range(POOL_N-1)] = id_n;
					add_event(cbfs_pkg::OP_RX, id_n, nc, phase_idle[ph], k == 0);
				end else if (r < 60) begin
					add_event(cbfs_pkg::OP_RX, id_pool[$urandom_range(POOL_N-1)], nc,
						phase_idle[ph], k == 0);
				end else if (r < 90) begin
					add_event(cbfs_pkg::OP_EXPIRE, id_pool[$urandom_range(POOL_N-1)], nc,
						phase_idle[ph], k == 0);
				end else begin
					add_event(1'($urandom_range(1)), $urandom, nc, phase_idle[ph], k == 0);
				end
			end
		end
		total = event_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted != total || expected_actions.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("ran %0d events incl. ring eviction and full-table cases", total);
		$display("saw %0d first receptions, %0d cancels, %0d forwards, %0d table-full",
			n_first, n_cancel, n_fwd, n_full);
		if (fail_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cbfs_pkg.sv
rtl/cbfs_pend.sv
rtl/cbfs_seen.sv
rtl/counter_based_flood_suppressor_unit.sv
test/testbench.sv
